[hw/rtl/scm_pkg.sv]
// Shared types, constants and table builders for the seam cost map column block.
`default_nettype none

package scm_pkg;

  localparam int PIXEL_BITS     = 8;
  localparam int FRAC_BITS      = 8;
  localparam int PEN_BITS       = 16;
  localparam int PEN_Q_BITS     = PEN_BITS + FRAC_BITS;
  localparam int ROWS_CFG_BITS  = 9;
  localparam int SHAPE_BITS     = 3;
  localparam int SMALL_BITS     = 9;
  localparam int USER_BITS      = 2;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  // tuser bit positions on the input side
  localparam int USER_BOUND = 0;
  localparam int USER_FIRST = 1;

  typedef enum logic [SHAPE_BITS-1:0] {
    SHAPE_LINEAR  = 3'd0,
    SHAPE_RECIP   = 3'd1,
    SHAPE_SQUARE  = 3'd2,
    SHAPE_EXP     = 3'd3,
    SHAPE_SIGMOID = 3'd4
  } shape_mode_e;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_PENALTY = 2'd0,
    CFG_SHAPE   = 2'd1,
    CFG_ROWS    = 2'd2
  } cfg_index_e;

  localparam logic [PEN_BITS-1:0]      PEN_RESET   = 16'd100;
  localparam shape_mode_e              SHAPE_RESET = SHAPE_SQUARE;
  localparam logic [ROWS_CFG_BITS-1:0] ROWS_RESET  = 9'd256;
  localparam logic [ROWS_CFG_BITS-1:0] MIN_ROWS    = 9'd3;
  localparam logic [PIXEL_BITS-1:0]    PIXEL_MAX   = 8'd255;

  // exp table: E[0] = 1.0 in Q.8, each step multiplies by e (Q.32 step)
  localparam logic [63:0] EXP_START   = 64'd256;
  localparam logic [63:0] EXP_STEP_HI = 64'd2;
  localparam logic [63:0] EXP_STEP_LO = 64'd3084996963;
  localparam logic [63:0] EXP_LIMIT   = 64'h5555_5555_5555_5555;
  localparam logic [63:0] EXP_HALF    = 64'h0000_0000_8000_0000;
  localparam logic [63:0] SIG_LIMIT   = 64'h0000_0100_0000_0000;
  localparam logic [SMALL_BITS-1:0] SIG_ONE = 9'd256;

  // Per-pixel classification handed from the accept stage to the cost datapath
  typedef struct packed {
    logic use_old;   // add the stored cost of this row
    logic add_pen;   // add the penalty on the straight path
    logic interior;  // take the minimum of three neighbours
    logic top;       // row 0
    logic last;      // last row of the column
  } item_kind_t;

  function automatic logic [63:0] exp_entry(input int k);
    logic [63:0] v;
    logic [63:0] hi;
    logic [63:0] lo;
    v = EXP_START;
    for (int i = 0; i < k; i++) begin
      if (v > EXP_LIMIT) begin
        v = '1;
      end else begin
        hi = v >> 32;
        lo = {32'h0, v[31:0]};
        v  = EXP_STEP_HI * v + hi * EXP_STEP_LO + ((lo * EXP_STEP_LO + EXP_HALF) >> 32);
      end
    end
    return v;
  endfunction

  // Quotient below 512 by shift-and-compare, elaboration use only
  function automatic logic [SMALL_BITS-1:0] quot_small(input logic [63:0] n,
                                                       input logic [63:0] d);
    logic [SMALL_BITS-1:0] q;
    logic [SMALL_BITS-1:0] t;
    q = '0;
    for (int b = SMALL_BITS - 1; b >= 0; b--) begin
      t = q | (SMALL_BITS'(1) << b);
      if (64'(t) * d <= n) q = t;
    end
    return q;
  endfunction

  function automatic logic [SMALL_BITS-1:0] recip_entry(input int x);
    logic [63:0] xv;
    xv = 64'(x);
    return quot_small(64'd513 * xv + 64'd1, 64'd2 * xv + 64'd2);
  endfunction

  function automatic logic [SMALL_BITS-1:0] sigmoid_entry(input logic [63:0] t);
    logic [SMALL_BITS-1:0] r;
    if (t > SIG_LIMIT) r = SIG_ONE;
    else r = quot_small(64'd513 * t + 64'd256, 64'd2 * t + 64'd512);
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/scm_shaper.sv]
// Pixel shaping: linear, x/(1+x), square, exp and sigmoid in Q.8.
`default_nettype none

module scm_shaper #(
  parameter int COST_BITS = 40
) (
  input  logic [scm_pkg::PIXEL_BITS-1:0] x_i,
  input  scm_pkg::shape_mode_e           mode_i,
  output logic [COST_BITS-1:0]           shape_o
);
  import scm_pkg::*;

  localparam int          NUM_X      = 1 << PIXEL_BITS;
  localparam logic [63:0] COST_MAX_W = {64{1'b1}} >> (64 - COST_BITS);

  logic [COST_BITS-1:0]    exp_tab [NUM_X];
  logic [SMALL_BITS-1:0]   rec_tab [NUM_X];
  logic [SMALL_BITS-1:0]   sig_tab [NUM_X];
  logic [2*PIXEL_BITS-1:0] sq;

  for (genvar g = 0; g < NUM_X; g++) begin : g_tab
    localparam logic [63:0] E = exp_entry(g);
    assign exp_tab[g] = (E > COST_MAX_W) ? COST_BITS'(COST_MAX_W) : COST_BITS'(E);
    assign rec_tab[g] = recip_entry(g);
    assign sig_tab[g] = sigmoid_entry(E);
  end

  assign sq = (2*PIXEL_BITS)'(x_i) * (2*PIXEL_BITS)'(x_i);

  always_comb begin
    case (mode_i)
      SHAPE_LINEAR:  shape_o = COST_BITS'({x_i, {FRAC_BITS{1'b0}}});
      SHAPE_RECIP:   shape_o = COST_BITS'(rec_tab[x_i]);
      SHAPE_SQUARE:  shape_o = COST_BITS'({sq, {FRAC_BITS{1'b0}}});
      SHAPE_EXP:     shape_o = exp_tab[x_i];
      SHAPE_SIGMOID: shape_o = COST_BITS'(sig_tab[x_i]);
      default:       shape_o = '0;
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/scm_col_mem.sv]
// Column cost store: one write and one registered read per cycle, write-first bypass.
`default_nettype none

module scm_col_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 40
) (
  input  logic                     clk_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
  end

  // same-entry read and write in one cycle returns the new word
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) rdata_q <= wdata_i;
      else rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hw/rtl/scm_cost_dp.sv]
// Cost datapath: three-operand saturating sums, minimum select, write-back and output register.
`default_nettype none

module scm_cost_dp #(
  parameter int MAX_ROWS  = 256,
  parameter int COST_BITS = 40
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            adv_i,
  input  logic                            s1_valid_i,
  input  scm_pkg::item_kind_t             s1_kind_i,
  input  logic [COST_BITS-1:0]            s1_shape_i,
  input  logic [$clog2(MAX_ROWS)-1:0]     s1_row_i,
  input  logic [scm_pkg::PEN_Q_BITS-1:0]  pen_i,
  input  logic [COST_BITS-1:0]            rdata_i,
  output logic                            we_o,
  output logic [$clog2(MAX_ROWS)-1:0]     waddr_o,
  output logic [COST_BITS-1:0]            wdata_o,
  output logic                            out_valid_o,
  output logic [COST_BITS-1:0]            out_cost_o,
  output logic                            out_last_o
);
  import scm_pkg::*;

  localparam int RW = $clog2(MAX_ROWS);
  localparam int SW = COST_BITS + 2;

  function automatic logic [COST_BITS-1:0] sat(input logic [SW-1:0] v);
    return (v[SW-1:COST_BITS] != '0) ? {COST_BITS{1'b1}} : v[COST_BITS-1:0];
  endfunction

  // history: stored cost of this row and old cost of the row above
  logic [COST_BITS-1:0] next_old_q, upper_q, row0_q;
  logic [COST_BITS-1:0] old_b;
  logic [SW-1:0]        sum_a, sum_up, sum_dn;

  logic                 s2_valid_q;
  logic [COST_BITS-1:0] s2_a_q, s2_up_q, s2_dn_q;
  logic                 s2_interior_q, s2_top_q, s2_last_q;
  logic [RW-1:0]        s2_row_q;

  logic [COST_BITS-1:0] low_c, cost_c;

  logic                 out_valid_q, out_last_q;
  logic [COST_BITS-1:0] out_cost_q;

  assign old_b  = s1_kind_i.top ? row0_q : next_old_q;
  assign sum_a  = SW'(s1_shape_i) + (s1_kind_i.use_old ? SW'(old_b) : '0)
                + (s1_kind_i.add_pen ? SW'(pen_i) : '0);
  assign sum_up = SW'(s1_shape_i) + SW'(upper_q) + SW'(pen_i);
  assign sum_dn = SW'(s1_shape_i) + SW'(rdata_i) + SW'(pen_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q <= '0;
    end else if (adv_i && s1_valid_i) begin
      upper_q <= old_b;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && s1_valid_i) next_old_q <= rdata_i;
    if (we_o && s2_top_q) row0_q <= cost_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      s2_valid_q  <= s1_valid_i;
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && s1_valid_i) begin
      s2_a_q        <= sat(sum_a);
      s2_up_q       <= sat(sum_up);
      s2_dn_q       <= sat(sum_dn);
      s2_interior_q <= s1_kind_i.interior;
      s2_top_q      <= s1_kind_i.top;
      s2_last_q     <= s1_kind_i.last;
      s2_row_q      <= s1_row_i;
    end
    if (we_o) begin
      out_cost_q <= cost_c;
      out_last_q <= s2_last_q;
    end
  end

  always_comb begin
    low_c = s2_a_q;
    if (s2_up_q < low_c) low_c = s2_up_q;
    if (s2_dn_q < low_c) low_c = s2_dn_q;
    cost_c = s2_interior_q ? low_c : s2_a_q;
  end

  assign we_o        = adv_i && s2_valid_q;
  assign waddr_o     = s2_row_q;
  assign wdata_o     = cost_c;
  assign out_valid_o = out_valid_q;
  assign out_cost_o  = out_cost_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

[hw/rtl/seam_cost_map_column_dp.sv]
// Top level of the horizontal seam cumulative cost map, one column per pass.
//
//  channel  | dir | handshake                       | payload
//  ---------+-----+---------------------------------+---------------------------------------
//  s_axis   | in  | s_axis_tvalid_i/s_axis_tready_o | tdata: pixel; tuser: boundary, first
//  m_axis   | out | m_axis_tvalid_o/m_axis_tready_i | tdata: cost (Q.8); tlast: column end
//  cfg      | in  | cfg_valid_i/cfg_ready_o         | cfg_index_i, cfg_data_i
//
// One word in and one word out per clock when both sides flow. A word taken on
// s_axis passes column store read and shaping, then the three-operand sums, then
// minimum select with write-back to the store, before it shows on m_axis.
// A stall on m_axis freezes all stages together; s_axis_tready_o stays high while
// the output register is empty or being drained.
// Reset clears control state and presets the configuration registers; the column store
// is not cleared and needs no sweep, a column must be seen with first_column set before use.
`default_nettype none

module seam_cost_map_column_dp #(
  parameter int MAX_ROWS  = 256,
  parameter int COST_BITS = 40
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // pixel words
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [scm_pkg::PIXEL_BITS-1:0]      s_axis_tdata_i,   // [7:0] pixel
  input  logic [scm_pkg::USER_BITS-1:0]       s_axis_tuser_i,   // [0] row_is_boundary, [1] first_column
  // cost words
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [((COST_BITS+7)/8)*8-1:0]      m_axis_tdata_o,   // [COST_BITS-1:0] cost, rest zero
  output logic                                m_axis_tlast_o,   // column_end
  // register writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [scm_pkg::CFG_INDEX_BITS-1:0]  cfg_index_i,
  input  logic [scm_pkg::CFG_DATA_BITS-1:0]   cfg_data_i
);
  import scm_pkg::*;

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int LW    = (RW + 1 > ROWS_CFG_BITS) ? RW + 1 : ROWS_CFG_BITS;
  localparam int OUT_W = ((COST_BITS + 7) / 8) * 8;

  // configuration
  logic [PEN_BITS-1:0]      pen_q;
  shape_mode_e              mode_q;
  logic [ROWS_CFG_BITS-1:0] rows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_q  <= PEN_RESET;
      mode_q <= SHAPE_RESET;
      rows_q <= ROWS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_PENALTY: pen_q  <= cfg_data_i[PEN_BITS-1:0];
        CFG_SHAPE:   mode_q <= shape_mode_e'(cfg_data_i[SHAPE_BITS-1:0]);
        CFG_ROWS:    rows_q <= cfg_data_i[ROWS_CFG_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // row count clamped to 3..MAX_ROWS
  logic [LW-1:0] rows_ext, rows_eff, rows_m1;

  always_comb begin
    rows_ext = LW'(rows_q);
    if (rows_ext < LW'(MIN_ROWS)) rows_eff = LW'(MIN_ROWS);
    else if (rows_ext > LW'(MAX_ROWS)) rows_eff = LW'(MAX_ROWS);
    else rows_eff = rows_ext;
    rows_m1 = rows_eff - LW'(1);
  end

  // handshake: every stage moves together when the output can take a word
  logic adv, accept;
  logic out_valid;

  assign adv             = !out_valid || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && adv;
  assign s_axis_tready_o = adv;

  // accept stage: row position, classification, shaping and store read
  logic [RW-1:0] row_q, row_d;
  logic          is_top, is_last, is_first, is_bound;
  item_kind_t    kind;
  logic [PIXEL_BITS-1:0] x_sel;
  logic [COST_BITS-1:0]  shape_w;
  logic [RW-1:0]         raddr;

  assign is_first = s_axis_tuser_i[USER_FIRST];
  assign is_bound = s_axis_tuser_i[USER_BOUND];
  assign is_top   = (row_q == '0);
  // past the last row counts as last (row count lowered mid-column)
  assign is_last  = (LW'(row_q) >= rows_m1);
  assign row_d    = is_last ? '0 : row_q + RW'(1);

  always_comb begin
    kind.top      = is_top;
    kind.last     = is_last;
    kind.use_old  = !is_first;
    kind.interior = !is_first && !is_top && !is_last && !is_bound;
    kind.add_pen  = is_first ? is_bound : !kind.interior;
  end

  // boundary rows strictly inside a later column take the shaped value of full white
  assign x_sel = (!is_first && !is_top && !is_last && is_bound) ? PIXEL_MAX : s_axis_tdata_i;

  // fetch the entry below this row; it is also the stored cost of the next row
  assign raddr = row_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) row_q <= '0;
    else if (accept) row_q <= row_d;
  end

  scm_shaper #(
    .COST_BITS (COST_BITS)
  ) u_shaper (
    .x_i     (x_sel),
    .mode_i  (mode_q),
    .shape_o (shape_w)
  );

  logic                 s1_valid_q;
  item_kind_t           s1_kind_q;
  logic [COST_BITS-1:0] s1_shape_q;
  logic [RW-1:0]        s1_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_valid_q <= 1'b0;
    else if (adv) s1_valid_q <= accept;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_kind_q  <= kind;
      s1_shape_q <= shape_w;
      s1_row_q   <= row_q;
    end
  end

  // column store
  logic                 mem_we;
  logic [RW-1:0]        mem_waddr;
  logic [COST_BITS-1:0] mem_wdata, mem_rdata;

  scm_col_mem #(
    .DEPTH (MAX_ROWS),
    .WIDTH (COST_BITS)
  ) u_col_mem (
    .clk_i   (clk_i),
    .re_i    (accept),
    .raddr_i (raddr),
    .rdata_o (mem_rdata),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata)
  );

  // sums, minimum and output register
  logic [COST_BITS-1:0] out_cost;
  logic                 out_last;

  scm_cost_dp #(
    .MAX_ROWS  (MAX_ROWS),
    .COST_BITS (COST_BITS)
  ) u_cost_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .s1_valid_i  (s1_valid_q),
    .s1_kind_i   (s1_kind_q),
    .s1_shape_i  (s1_shape_q),
    .s1_row_i    (s1_row_q),
    .pen_i       ({pen_q, {FRAC_BITS{1'b0}}}),
    .rdata_i     (mem_rdata),
    .we_o        (mem_we),
    .waddr_o     (mem_waddr),
    .wdata_o     (mem_wdata),
    .out_valid_o (out_valid),
    .out_cost_o  (out_cost),
    .out_last_o  (out_last)
  );

  assign m_axis_tvalid_o = out_valid;
  assign m_axis_tdata_o  = OUT_W'(out_cost);
  assign m_axis_tlast_o  = out_last;

endmodule

`default_nettype wire

[hw/rtl/scm_checker.sv]
// Port-level checks for the seam cost map column block, bound to the top level.
`default_nettype none

module scm_checker #(
  parameter int COST_BITS = 40
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid_i,
  input logic                           s_axis_tready_o,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [((COST_BITS+7)/8)*8-1:0] m_axis_tdata_o,
  input logic                           m_axis_tlast_o
);

  // words taken but not yet delivered; three pipeline places at most
  logic [2:0] inflight_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + 3'((s_axis_tvalid_i && s_axis_tready_o))
                                - 3'((m_axis_tvalid_o && m_axis_tready_i));
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output word changed while stalled");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= 3'd3)
    else $error("more words in flight than pipeline places");

  a_no_ghost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q == 3'd0 |-> !m_axis_tvalid_o)
    else $error("output word with nothing accepted");

  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input refused with empty output register");

endmodule

bind seam_cost_map_column_dp scm_checker #(.COST_BITS(COST_BITS)) u_scm_checker (.*);

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the seam cost map column block: directed cases, then random columns.
`default_nettype none

module testbench;
  import scm_pkg::*;

  localparam int          COST_W      = 40;
  localparam int          ROWS_MAX    = 256;
  localparam int          RAND_ITEMS  = 1000;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [63:0] COST_SAT    = (64'd1 << COST_W) - 64'd1;
  // e in Q.32 is 2^33 + STEP_LO; the growth stops once a further step could wrap
  localparam logic [63:0] STEP_LO     = 64'd3084996963;
  localparam logic [63:0] EXP_CAP     = 64'hFFFF_FFFF_FFFF_FFFF / 64'd3;
  localparam logic [63:0] SIG_CAP     = 64'd1 << 40;

  // receiver behaviour, re-chosen whenever the phase counter wraps
  typedef enum logic [1:0] {
    RX_FREE,    // always ready
    RX_COIN,    // ready on a coin toss
    RX_MASK,    // ready follows a rotating 8-bit mask
    RX_SPARSE   // ready with a chance of one in four
  } rx_kind_e;

  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic              col_end;
  } cost_word_t;

  logic                      clk_i           = 1'b0;
  logic                      rst_ni          = 1'b0;
  logic                      s_axis_tvalid_i = 1'b0;
  logic                      s_axis_tready_o;
  logic [PIXEL_BITS-1:0]     s_axis_tdata_i  = '0;
  logic [USER_BITS-1:0]      s_axis_tuser_i  = '0;   // [0] row_is_boundary, [1] first_column
  logic                      m_axis_tvalid_o;
  logic                      m_axis_tready_i = 1'b0;
  logic [COST_W-1:0]         m_axis_tdata_o;         // [39:0] cost
  logic                      m_axis_tlast_o;         // column_end
  logic                      cfg_valid_i     = 1'b0;
  logic                      cfg_ready_o;
  logic [CFG_INDEX_BITS-1:0] cfg_index_i     = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data_i      = '0;

  // predictor state, mirrors the block's registers and column store
  logic [63:0]         exp_lut     [256];
  logic [COST_W-1:0]   col_cost    [ROWS_MAX];
  bit                  col_written [ROWS_MAX];
  int unsigned         row_cnt     = 0;
  logic [COST_W-1:0]   upper_old   = '0;
  bit                  upper_known = 1'b1;   // upper_old came from a written entry
  logic [PEN_BITS-1:0] pen_cfg     = PEN_RESET;
  logic [2:0]          shape_cfg   = SHAPE_RESET;
  logic [8:0]          rows_cfg    = ROWS_RESET;

  cost_word_t  pending_costs[$];
  int unsigned bad_cnt    = 0;
  int unsigned sent_cnt   = 0;
  int unsigned burst_left = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned rx_phase   = 0;
  rx_kind_e    rx_kind    = RX_FREE;
  logic [7:0]  rx_mask    = 8'hFF;

  seam_cost_map_column_dp DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned rows_eff();
    int unsigned n;
    n = rows_cfg;
    if (n < 3) n = 3;
    if (n > ROWS_MAX) n = ROWS_MAX;
    return n;
  endfunction

  function automatic logic [63:0] sum_sat(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return (s > COST_SAT) ? COST_SAT : s;
  endfunction

  // pixel shaping, Q.8, clamped to the cost width
  function automatic logic [63:0] shaped(input logic [PIXEL_BITS-1:0] x);
    logic [63:0] xv;
    logic [63:0] t;
    logic [63:0] s;
    xv = 64'(x);
    case (shape_cfg)
      SHAPE_LINEAR:  s = xv << 8;
      SHAPE_RECIP:   s = (64'd513 * xv + 64'd1) / (64'd2 * xv + 64'd2);
      SHAPE_SQUARE:  s = (xv * xv) << 8;
      SHAPE_EXP:     s = exp_lut[x];
      SHAPE_SIGMOID: begin
        t = exp_lut[x];
        s = (t > SIG_CAP) ? 64'd256 : (64'd513 * t + 64'd256) / (64'd2 * t + 64'd512);
      end
      default:       s = '0;   // undefined modes shape to zero
    endcase
    return (s > COST_SAT) ? COST_SAT : s;
  endfunction

  // A later-column pixel may only read store entries that hold a real cost
  function automatic bit store_ready(input logic bound);
    int unsigned r;
    r = row_cnt;
    if (!col_written[r]) return 1'b0;
    if (r == 0 || r >= rows_eff() - 1 || bound) return 1'b1;
    return col_written[r+1] && upper_known;
  endfunction

  // Cost of one accepted pixel; advances the predictor state
  function automatic cost_word_t next_cost(input logic [PIXEL_BITS-1:0] px, input logic bound,
                                           input logic first);
    int unsigned r;
    logic        last;
    logic [63:0] pq;
    logic [63:0] old;
    logic [63:0] low;
    logic [63:0] up;
    logic [63:0] dn;
    logic [63:0] c;
    cost_word_t  w;
    r    = row_cnt;
    last = (r >= rows_eff() - 1);   // also covers a counter left past a lowered row count
    pq   = 64'(pen_cfg) << 8;
    old  = 64'(col_cost[r]);
    if (first) begin
      c = shaped(px);
      if (bound) c = sum_sat(c, pq);
    end else if (r == 0 || last) begin
      c = sum_sat(sum_sat(shaped(px), old), pq);
    end else if (bound) begin
      c = sum_sat(sum_sat(old, shaped(PIXEL_MAX)), pq);
    end else begin
      low = old;
      up  = sum_sat(64'(upper_old), pq);
      dn  = sum_sat(64'(col_cost[r+1]), pq);
      if (up < low) low = up;
      if (dn < low) low = dn;
      c = sum_sat(low, shaped(px));
    end
    upper_known    = col_written[r];
    upper_old      = old[COST_W-1:0];
    col_cost[r]    = c[COST_W-1:0];
    col_written[r] = 1'b1;
    row_cnt        = last ? 0 : r + 1;
    w.cost         = c[COST_W-1:0];
    w.col_end      = last;
    return w;
  endfunction

  // ---------------------------------------------------------------- checker

  always @(posedge clk_i) begin
    cost_word_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_costs.size() == 0) begin
        bad_cnt++;
        if (bad_cnt <= 10)
          $display("unexpected cost word: cost %0d end %0b", m_axis_tdata_o, m_axis_tlast_o);
      end else begin
        want = pending_costs.pop_front();
        if (m_axis_tdata_o !== want.cost || m_axis_tlast_o !== want.col_end) begin
          bad_cnt++;
          if (bad_cnt <= 10)
            $display("cost mismatch: exp cost %0d end %0b, got cost %0d end %0b",
                     want.cost, want.col_end, m_axis_tdata_o, m_axis_tlast_o);
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver stalls

  always @(negedge clk_i) begin
    if (rx_phase == 0) begin
      rx_kind <= rx_kind_e'($urandom_range(0, 3));
      rx_mask <= 8'($urandom);
    end
    rx_phase <= (rx_phase == 79) ? 0 : rx_phase + 1;
    case (rx_kind)
      RX_FREE:   m_axis_tready_i <= 1'b1;
      RX_COIN:   m_axis_tready_i <= 1'($urandom_range(0, 1));
      RX_MASK:   m_axis_tready_i <= rx_mask[rx_phase % 8];
      default:   m_axis_tready_i <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // ---------------------------------------------------------------- sender

  // One pixel word; the expected cost is queued on acceptance. A later-column
  // pixel that would read an unwritten store entry is sent as first column.
  task automatic send_pixel(input logic [PIXEL_BITS-1:0] px, input logic bound,
                            input logic first);
    logic                 first_eff;
    logic [USER_BITS-1:0] user;
    cost_word_t           exp_w;
    first_eff        = first | !store_ready(bound);
    user             = '0;
    user[USER_BOUND] = bound;
    user[USER_FIRST] = first_eff;
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= px;
    s_axis_tuser_i  <= user;
    do @(posedge clk_i); while (!s_axis_tready_o);
    exp_w = next_cost(px, bound, first_eff);
    pending_costs.insert(pending_costs.size(), exp_w);
    sent_cnt++;
  endtask

  // Bursts of random length with random gaps; long bursts give gap-free stretches
  task automatic feed_pixel(input logic [PIXEL_BITS-1:0] px, input logic bound,
                            input logic first);
    int unsigned gap;
    send_pixel(px, bound, first);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        @(negedge clk_i) s_axis_tvalid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 12);
    end
  endtask

  // Sender holds off until every expected cost word has come back
  task automatic drain_words();
    @(negedge clk_i) s_axis_tvalid_i <= 1'b0;
    while (pending_costs.size() != 0) @(posedge clk_i);
  endtask

  // Register write, only with the pipeline empty
  task automatic write_reg(input cfg_index_e idx, input logic [CFG_DATA_BITS-1:0] val);
    drain_words();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_PENALTY: pen_cfg   = val;
      CFG_SHAPE:   shape_cfg = val[2:0];
      CFG_ROWS:    rows_cfg  = val[8:0];
      default:     ;
    endcase
    @(negedge clk_i) cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [PIXEL_BITS-1:0] rand_pixel();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return PIXEL_MAX;
      default: return PIXEL_BITS'($urandom_range(0, 255));
    endcase
  endfunction

  // Pixels until the column closes; first_column flips now and then
  task automatic send_column(input logic first);
    do
      feed_pixel(rand_pixel(), $urandom_range(0, 7) == 0, first ^ ($urandom_range(0, 19) == 0));
    while (row_cnt != 0);
  endtask

  // ---------------------------------------------------------------- tests

  // Every shaping mode, undefined ones too, on a first column, each at one pixel extreme
  task automatic test_shaping_modes();
    logic [2:0] m;
    write_reg(CFG_ROWS, 16'd4);
    write_reg(CFG_PENALTY, 16'd0);
    for (int i = 0; i < 8; i++) begin
      m = 3'(i);
      write_reg(CFG_SHAPE, 16'(m));
      feed_pixel(m[0] ? PIXEL_MAX : 8'd0, m[1], 1'b1);
    end
  endtask

  // Top, last, boundary and interior rows at the largest penalty, then saturation
  task automatic test_cost_rules();
    write_reg(CFG_PENALTY, 16'hFFFF);
    write_reg(CFG_SHAPE, 16'(SHAPE_SQUARE));
    write_reg(CFG_ROWS, 16'(MIN_ROWS));
    feed_pixel(8'd255, 1'b0, 1'b1);
    feed_pixel(8'd0,   1'b1, 1'b1);
    feed_pixel(8'd128, 1'b0, 1'b1);
    // boundary in the middle takes the shaped 255
    feed_pixel(8'd255, 1'b0, 1'b0);
    feed_pixel(8'd7,   1'b1, 1'b0);
    feed_pixel(8'd0,   1'b0, 1'b0);
    // interior minimum; boundary flag on the last row has no effect
    feed_pixel(8'd1,   1'b0, 1'b0);
    feed_pixel(8'd200, 1'b0, 1'b0);
    feed_pixel(8'd255, 1'b1, 1'b0);
    // exp of 255 overflows the cost width: every sum saturates
    write_reg(CFG_SHAPE, 16'(SHAPE_EXP));
    repeat (3) feed_pixel(PIXEL_MAX, 1'b0, 1'b0);
  endtask

  // Row count lowered under a running counter, and out-of-range row counts
  task automatic test_row_count_change();
    write_reg(CFG_SHAPE, 16'(SHAPE_LINEAR));
    write_reg(CFG_PENALTY, 16'd1);
    write_reg(CFG_ROWS, 16'd8);
    repeat (5) feed_pixel(rand_pixel(), 1'b0, 1'b1);
    // counter now at 5, past the new last row: closes the column
    write_reg(CFG_ROWS, 16'(MIN_ROWS));
    feed_pixel(8'd9, 1'b0, 1'b0);
    write_reg(CFG_ROWS, 16'd2);
    repeat (3) feed_pixel(rand_pixel(), 1'b0, 1'b0);
    write_reg(CFG_ROWS, 16'd511);
  endtask

  // Well-formed images under changing settings, with some loose pixels between
  task automatic test_random_columns();
    int unsigned goal;
    int unsigned n_cols;
    int unsigned pick;
    logic [8:0]  rows_w;
    logic [CFG_DATA_BITS-1:0] pen_w;
    goal = sent_cnt + RAND_ITEMS;
    while (sent_cnt < goal) begin
      case ($urandom_range(0, 4))
        0:       pen_w = '0;
        1:       pen_w = '1;
        2:       pen_w = 16'($urandom_range(0, 255));
        default: pen_w = 16'($urandom);
      endcase
      pick = $urandom_range(0, 19);
      if (pick == 0)      rows_w = 9'd256;
      else if (pick == 1) rows_w = 9'($urandom_range(0, 2));
      else if (pick == 2) rows_w = 9'($urandom_range(257, 511));
      else                rows_w = 9'($urandom_range(3, 16));
      // upper data bits are don't-care for the narrow registers
      write_reg(CFG_PENALTY, pen_w);
      write_reg(CFG_SHAPE, {13'($urandom), 3'($urandom_range(0, 7))});
      write_reg(CFG_ROWS, {7'($urandom), rows_w});
      n_cols = (rows_eff() > 64) ? 2 : $urandom_range(3, 10);
      send_column(1'b1);
      repeat (n_cols - 1) send_column(1'b0);
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 8))
          feed_pixel(rand_pixel(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    logic [63:0] v;
    logic [63:0] hi;
    logic [63:0] lo;
    // exp table in Q.8, each step times e with rounding
    v = 64'd256;
    for (int k = 0; k < 256; k++) begin
      exp_lut[k] = v;
      if (v > EXP_CAP) begin
        v = '1;
      end else begin
        hi = v >> 32;
        lo = v & 64'hFFFF_FFFF;
        v  = 64'd2 * v + hi * STEP_LO + ((lo * STEP_LO + 64'h8000_0000) >> 32);
      end
    end
    for (int k = 0; k < ROWS_MAX; k++) begin
      col_cost[k]    = '0;
      col_written[k] = 1'b0;
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    test_shaping_modes();
    test_cost_rules();
    test_row_count_change();
    test_random_columns();

    drain_words();
    repeat (8) @(posedge clk_i);
    if (bad_cnt == 0 && pending_costs.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
hw/rtl/scm_pkg.sv
hw/rtl/scm_shaper.sv
hw/rtl/scm_col_mem.sv
hw/rtl/scm_cost_dp.sv
hw/rtl/seam_cost_map_column_dp.sv
hw/rtl/scm_checker.sv
tb/testbench.sv
